// ===== sv/swdm_pkg.sv =====
// Shared types, constants and helpers for the stereo wet/dry mixer with soft mute.
// No dependencies; imported by every module of the block.
package swdm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 12;
  localparam int MIX_FULL   = 4095;
  localparam int MIX_SHIFT  = 12;
  localparam int RAMP_SHIFT = 9;
  localparam int RAMP_LEN   = 512;
  localparam int CNT_W      = $clog2(RAMP_LEN + 1);

  localparam int PROD_W  = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int MIX_W   = SUM_W - MIX_SHIFT;
  localparam int RPROD_W = SAMPLE_W + CNT_W + 1;
  localparam int RSH_W   = RPROD_W - RAMP_SHIFT;
  localparam int SAT_W   = 32;

  typedef logic [1:0] func_t;
  localparam func_t FN_FRAME = 2'd0;
  localparam func_t FN_MUTE  = 2'd1;
  localparam func_t FN_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    PH_UNMUTED = 2'd0,
    PH_DOWN    = 2'd1,
    PH_MUTED   = 2'd2,
    PH_UP      = 2'd3
  } mute_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_SCALE
  } ctl_state_t;

  typedef struct packed {
    func_t                       func;
    logic signed [SAMPLE_W-1:0]  dry_left;
    logic signed [SAMPLE_W-1:0]  dry_right;
    logic signed [SAMPLE_W-1:0]  wet_left;
    logic signed [SAMPLE_W-1:0]  wet_right;
    logic [GAIN_W-1:0]           wet_gain;
    logic                        mute_enable;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  out_left;
    logic signed [SAMPLE_W-1:0]  out_right;
    logic [SAMPLE_W-1:0]         in_peak_left;
    logic [SAMPLE_W-1:0]         in_peak_right;
    logic [SAMPLE_W-1:0]         out_peak_left;
    logic [SAMPLE_W-1:0]         out_peak_right;
    logic [1:0]                  mute_phase_now;
  } out_item_t;

  typedef struct packed {
    logic ld;
    logic adv;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0]        in_mag;
    logic [SAMPLE_W-1:0]        out_mag;
  } lane_res_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_W-1:0] x);
    logic signed [SAMPLE_W-1:0] r;
    if (x > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // |-32768| wraps to 16'h8000, which is the held magnitude 32768
  function automatic logic [SAMPLE_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] r;
    if (s[SAMPLE_W-1]) begin
      r = ~s + 1'b1;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== sv/stereo_wet_dry_mix_soft_mute.sv =====
// Top level: stereo wet/dry crossfade with soft-mute ramp and peak meters.
// Depends on swdm_pkg, swdm_lane (one per channel) and swdm_merge.
//
//   channel   ports                          direction   handshake
//   input     in_valid  in_ready  in_data    in          valid/ready, in_item_t
//   result    out_valid out_ready out_data   out         valid/ready, out_item_t
//
// Every item gives one result: its mix products, then its ramp product, are
// registered in turn, then the commit goes into the result register.
// A new item is taken on the commit cycle of the previous one, so an item is not
// taken before the one ahead of it commits; each lane has two multiplier stages.
// A result waiting on out_ready holds the item behind it in the last stage.
// Reset (rst_n low, synchronous) leaves the block muted with meters cleared.
module stereo_wet_dry_mix_soft_mute import swdm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctl_state_t       state_r, state_nxt;
  func_t            func_r;
  logic             mute_r;
  logic             accept;
  logic             commit;
  lane_ctl_t        lane_ctl;
  lane_res_t        res_l, res_r;
  mute_phase_t      phase;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    commit       = rst_n && (state_r == ST_SCALE) && (!out_valid || out_ready);
    in_ready     = rst_n && ((state_r == ST_IDLE) || commit);
    accept       = in_valid && in_ready;
    lane_ctl.ld  = accept;
    lane_ctl.adv = (state_r == ST_MIX);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_SCALE;
      ST_SCALE: begin
        if (commit) state_nxt = accept ? ST_MIX : ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_data.func;
      mute_r <= in_data.mute_enable;
    end
  end

  swdm_lane u_lane_l (
    .clk   (clk),
    .ctl   (lane_ctl),
    .dry   (in_data.dry_left),
    .wet   (in_data.wet_left),
    .gain  (in_data.wet_gain),
    .phase (phase),
    .cnt   (cnt),
    .res   (res_l)
  );

  swdm_lane u_lane_r (
    .clk   (clk),
    .ctl   (lane_ctl),
    .dry   (in_data.dry_right),
    .wet   (in_data.wet_right),
    .gain  (in_data.wet_gain),
    .phase (phase),
    .cnt   (cnt),
    .res   (res_r)
  );

  swdm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (commit),
    .func      (func_r),
    .mute_en   (mute_r),
    .res_l     (res_l),
    .res_r     (res_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .phase     (phase),
    .cnt       (cnt)
  );

endmodule

// ===== sv/swdm_lane.sv =====
// One channel lane: wet/dry crossfade, saturation and soft-mute ramp scaling.
// Depends on swdm_pkg.
module swdm_lane import swdm_pkg::*; (
  input  logic                       clk,
  input  lane_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] dry,
  input  logic signed [SAMPLE_W-1:0] wet,
  input  logic [GAIN_W-1:0]          gain,
  input  mute_phase_t                phase,
  input  logic [CNT_W-1:0]           cnt,
  output lane_res_t                  res
);

  logic signed [PROD_W-1:0]   prod_w_r, prod_w_nxt;
  logic signed [PROD_W-1:0]   prod_d_r, prod_d_nxt;
  logic signed [SAMPLE_W-1:0] dry_r;
  logic signed [SAMPLE_W-1:0] mix_r, mix_nxt;
  logic signed [RPROD_W-1:0]  rprod_r, rprod_nxt;

  logic [GAIN_W-1:0]          dry_gain;
  logic signed [SUM_W-1:0]    sum;
  logic signed [MIX_W-1:0]    mix_shr;
  logic signed [RSH_W-1:0]    ramp_shr;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0] sample;

  always_comb begin
    dry_gain   = GAIN_W'(MIX_FULL) - gain;
    prod_w_nxt = wet * $signed({1'b0, gain});
    prod_d_nxt = dry * $signed({1'b0, dry_gain});
  end

  always_comb begin
    sum       = $signed({prod_w_r[PROD_W-1], prod_w_r}) + $signed({prod_d_r[PROD_W-1], prod_d_r});
    mix_shr   = sum[SUM_W-1:MIX_SHIFT];
    mix_nxt   = sat16($signed({{(SAT_W-MIX_W){mix_shr[MIX_W-1]}}, mix_shr}));
    rprod_nxt = mix_nxt * $signed({1'b0, cnt});
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      prod_w_r <= prod_w_nxt;
      prod_d_r <= prod_d_nxt;
      dry_r    <= dry;
    end
    if (ctl.adv) begin
      mix_r   <= mix_nxt;
      rprod_r <= rprod_nxt;
    end
  end

  always_comb begin
    ramp_shr = rprod_r[RPROD_W-1:RAMP_SHIFT];
    scaled   = sat16($signed({{(SAT_W-RSH_W){ramp_shr[RSH_W-1]}}, ramp_shr}));
    unique case (phase)
      PH_UNMUTED: sample = mix_r;
      PH_MUTED:   sample = '0;
      PH_DOWN,
      PH_UP:      sample = scaled;
      default:    sample = '0;
    endcase
    res.sample  = sample;
    res.in_mag  = mag16(dry_r);
    res.out_mag = mag16(sample);
  end

endmodule

// ===== sv/swdm_merge.sv =====
// Merge stage: peak meters, mute phase and ramp counter, and the result register.
// Depends on swdm_pkg; combines the two swdm_lane results.
module swdm_merge import swdm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             commit,
  input  func_t            func,
  input  logic             mute_en,
  input  lane_res_t        res_l,
  input  lane_res_t        res_r,
  input  logic             out_ready,
  output logic             out_valid,
  output out_item_t        out_data,
  output mute_phase_t      phase,
  output logic [CNT_W-1:0] cnt
);

  mute_phase_t          phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0]  pk_il_r, pk_il_nxt;
  logic [SAMPLE_W-1:0]  pk_ir_r, pk_ir_nxt;
  logic [SAMPLE_W-1:0]  pk_ol_r, pk_ol_nxt;
  logic [SAMPLE_W-1:0]  pk_or_r, pk_or_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic signed [SAMPLE_W-1:0] smp_l, smp_r;
  logic [CNT_W-1:0]     cnt_dec;
  logic [CNT_W:0]       cnt_inc;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    pk_il_nxt = pk_il_r;
    pk_ir_nxt = pk_ir_r;
    pk_ol_nxt = pk_ol_r;
    pk_or_nxt = pk_or_r;
    smp_l     = '0;
    smp_r     = '0;
    cnt_dec   = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
    cnt_inc   = {1'b0, cnt_r} + 1'b1;
    unique case (func)
      FN_FRAME: begin
        smp_l = res_l.sample;
        smp_r = res_r.sample;
        if (res_l.in_mag > pk_il_r)  pk_il_nxt = res_l.in_mag;
        if (res_r.in_mag > pk_ir_r)  pk_ir_nxt = res_r.in_mag;
        if (res_l.out_mag > pk_ol_r) pk_ol_nxt = res_l.out_mag;
        if (res_r.out_mag > pk_or_r) pk_or_nxt = res_r.out_mag;
        unique case (phase_r)
          PH_DOWN: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == '0) phase_nxt = PH_MUTED;
          end
          PH_UP: begin
            if (cnt_inc >= (CNT_W+1)'(RAMP_LEN)) begin
              phase_nxt = PH_UNMUTED;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = cnt_inc[CNT_W-1:0];
            end
          end
          PH_UNMUTED,
          PH_MUTED: ;
          default: ;
        endcase
      end
      FN_MUTE: begin
        if (phase_r == PH_UNMUTED && mute_en) begin
          cnt_nxt   = CNT_W'(RAMP_LEN);
          phase_nxt = PH_DOWN;
        end else if (phase_r == PH_MUTED && !mute_en) begin
          cnt_nxt   = '0;
          phase_nxt = PH_UP;
        end
      end
      FN_CLEAR: begin
        pk_il_nxt = '0;
        pk_ir_nxt = '0;
        pk_ol_nxt = '0;
        pk_or_nxt = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data_nxt.out_left       = smp_l;
    out_data_nxt.out_right      = smp_r;
    out_data_nxt.in_peak_left   = pk_il_nxt;
    out_data_nxt.in_peak_right  = pk_ir_nxt;
    out_data_nxt.out_peak_left  = pk_ol_nxt;
    out_data_nxt.out_peak_right = pk_or_nxt;
    out_data_nxt.mute_phase_now = phase_nxt;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MUTED;
      cnt_r       <= '0;
      pk_il_r     <= '0;
      pk_ir_r     <= '0;
      pk_ol_r     <= '0;
      pk_or_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        pk_il_r <= pk_il_nxt;
        pk_ir_r <= pk_ir_nxt;
        pk_ol_r <= pk_ol_nxt;
        pk_or_r <= pk_or_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign phase     = phase_r;
  assign cnt       = cnt_r;

endmodule
